FILE: design/nddi_pkg.sv
package nddi_pkg;

   // Command codes of an input item
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Status codes of a result item
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DUP_X    = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   // Restoring divider: 64-bit numerator shifted up by 16
   localparam int DIV_STEPS = 80;
   localparam int DIV_CNT_W = 7;

   // Commands from controller to datapath
   typedef struct packed {
      logic x_wr;
      logic c_wr_load;
      logic c_wr_div;
      logic cap_a;
      logic cap_b;
      logic prep;
      logic div_init;
      logic div_step;
      logic acc_load;
      logic q_cap;
      logic mul_lo;
      logic mul_hi;
      logic q_sum;
      logic q_add;
      logic q_fin;
      logic pend_zero;
      logic out_load;
      logic qx_load;
   } nddi_cmd_type;

   // Sign and magnitude to 64-bit two's complement, saturating
   function automatic logic [63:0] sat_sm(input logic neg, input logic [80:0] mag);
      logic [63:0] m;
      begin
         if (neg) begin
            if (mag > 81'h0_8000_0000_0000_0000) m = 64'h8000_0000_0000_0000;
            else                                 m = mag[63:0];
            sat_sm = ~m + 64'd1;
         end else begin
            if (mag > 81'h0_7FFF_FFFF_FFFF_FFFF) sat_sm = 64'h7FFF_FFFF_FFFF_FFFF;
            else                                 sat_sm = mag[63:0];
         end
      end
   endfunction

   // Saturating 64-bit signed add
   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      begin
         s = a + b;
         if ((a[63] == b[63]) && (s[63] != a[63]))
            sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         else
            sat_add = s;
      end
   endfunction

endpackage

FILE: design/nddi_ram.sv
module nddi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/nddi_dp.sv
module nddi_dp import nddi_pkg::*; #(
   parameter int MAX_POINTS = 7
) (
   input  logic                          clock,
   input  nddi_cmd_type                  cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] c_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] x_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  logic signed [31:0]            req_x_value,
   input  logic signed [31:0]            req_y_value,
   output logic                          den_zero,
   output logic signed [31:0]            rsp_result_value
);

   logic [63:0]  c_rd;
   logic [31:0]  x_rd;
   logic [63:0]  c_wr_data;
   logic         c_wr_en;

   logic [63:0]  ca_ff, cb_ff;
   logic [31:0]  xa_ff, xb_ff;
   logic [63:0]  num_ff;
   logic [32:0]  den_ff;
   logic         qneg_ff;
   logic [79:0]  dvd_ff;
   logic [33:0]  rem_ff;
   logic [79:0]  quo_ff;
   logic [31:0]  qx_ff;
   logic [63:0]  acc_ff;
   logic [63:0]  amag_ff;
   logic [32:0]  dmag_ff;
   logic         pneg_ff;
   logic [64:0]  plo_ff, phi_ff;
   logic [63:0]  prod_ff;
   logic [31:0]  pend_ff;
   logic [31:0]  out_ff;

   logic [64:0]  num_diff;
   logic [64:0]  num_mag;
   logic [32:0]  den_diff;
   logic [32:0]  den_mag;
   logic [33:0]  rem_sh;
   logic         rem_ge;
   logic [32:0]  qd_diff;
   logic [32:0]  qd_mag;
   logic [63:0]  acc_mag;
   logic [31:0]  mul_a;
   logic [64:0]  mul_p;
   logic [96:0]  full_p;
   logic [47:0]  fin_mag;
   logic [31:0]  fin_m;
   logic [31:0]  fin_val;

   // Coefficient and abscissa stores
   assign c_wr_en   = cmd.c_wr_load | cmd.c_wr_div;
   assign c_wr_data = cmd.c_wr_load ? {{16{req_y_value[31]}}, req_y_value, 16'd0}
                                    : sat_sm(qneg_ff, {1'b0, quo_ff});

   nddi_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_addr),
      .rd_data (c_rd)
   );

   nddi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (cmd.x_wr),
      .wr_addr (wr_addr),
      .wr_data (req_x_value),
      .rd_addr (x_addr),
      .rd_data (x_rd)
   );

   // Differences for one division
   always_comb begin
      num_diff = {ca_ff[63], ca_ff} - {cb_ff[63], cb_ff};
      num_mag  = num_diff[64] ? (~num_diff + 65'd1) : num_diff;
      den_diff = {xa_ff[31], xa_ff} - {xb_ff[31], xb_ff};
      den_mag  = den_diff[32] ? (~den_diff + 33'd1) : den_diff;
   end

   assign den_zero = (den_ff == 33'd0);

   // One quotient bit per step
   always_comb begin
      rem_sh = {rem_ff[32:0], dvd_ff[79]};
      rem_ge = (rem_sh >= {1'b0, den_ff});
   end

   // Query difference and accumulator magnitude
   always_comb begin
      qd_diff = {qx_ff[31], qx_ff} - {x_rd[31], x_rd};
      qd_mag  = qd_diff[32] ? (~qd_diff + 33'd1) : qd_diff;
      acc_mag = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;
   end

   // Shared 32x33 multiplier over two halves
   assign mul_a  = cmd.mul_hi ? amag_ff[63:32] : amag_ff[31:0];
   assign mul_p  = 65'(mul_a * dmag_ff);
   assign full_p = {phi_ff, 32'd0} + {32'd0, plo_ff};

   // Q32.32 accumulator to Q16.16 with saturation
   always_comb begin
      fin_mag = acc_mag[63:16];
      if (acc_ff[63]) begin
         fin_m   = (fin_mag > 48'h0000_8000_0000) ? 32'h8000_0000 : fin_mag[31:0];
         fin_val = ~fin_m + 32'd1;
      end else begin
         fin_m   = (fin_mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : fin_mag[31:0];
         fin_val = fin_m;
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         ca_ff <= c_rd;
         xa_ff <= x_rd;
      end
      if (cmd.cap_b) begin
         cb_ff <= c_rd;
         xb_ff <= x_rd;
      end
      if (cmd.prep) begin
         num_ff  <= num_mag[63:0];
         den_ff  <= den_mag;
         qneg_ff <= num_diff[64] ^ den_diff[32];
      end
      if (cmd.div_init) begin
         dvd_ff <= {num_ff, 16'd0};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[78:0], 1'b0};
         rem_ff <= rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_ff <= {quo_ff[78:0], rem_ge};
      end
      if (cmd.qx_load) begin
         qx_ff <= req_x_value;
      end
      if (cmd.acc_load) begin
         acc_ff <= c_rd;
      end else if (cmd.q_add) begin
         acc_ff <= sat_add(prod_ff, cb_ff);
      end
      if (cmd.q_cap) begin
         cb_ff   <= c_rd;
         dmag_ff <= qd_mag;
         amag_ff <= acc_mag;
         pneg_ff <= acc_ff[63] ^ qd_diff[32];
      end
      if (cmd.mul_lo) begin
         plo_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         phi_ff <= mul_p;
      end
      if (cmd.q_sum) begin
         prod_ff <= sat_sm(pneg_ff, full_p[96:16]);
      end
      if (cmd.pend_zero) begin
         pend_ff <= '0;
      end else if (cmd.q_fin) begin
         pend_ff <= fin_val;
      end
      if (cmd.out_load) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_result_value = out_ff;

endmodule

FILE: design/nddi_ctrl.sv
module nddi_ctrl import nddi_pkg::*; #(
   parameter int MAX_POINTS = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   input  logic                          den_zero,
   output nddi_cmd_type                  cmd,
   output logic [$clog2(MAX_POINTS)-1:0] c_addr,
   output logic [$clog2(MAX_POINTS)-1:0] x_addr,
   output logic [$clog2(MAX_POINTS)-1:0] wr_addr
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_B_RD1 = 5'd1;
   localparam logic [4:0] S_B_RD2 = 5'd2;
   localparam logic [4:0] S_B_CAP = 5'd3;
   localparam logic [4:0] S_B_PRE = 5'd4;
   localparam logic [4:0] S_B_CHK = 5'd5;
   localparam logic [4:0] S_B_DIV = 5'd6;
   localparam logic [4:0] S_B_WR  = 5'd7;
   localparam logic [4:0] S_Q_RD0 = 5'd8;
   localparam logic [4:0] S_Q_LD  = 5'd9;
   localparam logic [4:0] S_Q_RD  = 5'd10;
   localparam logic [4:0] S_Q_CAP = 5'd11;
   localparam logic [4:0] S_Q_ML  = 5'd12;
   localparam logic [4:0] S_Q_MH  = 5'd13;
   localparam logic [4:0] S_Q_SUM = 5'd14;
   localparam logic [4:0] S_Q_ADD = 5'd15;
   localparam logic [4:0] S_Q_FIN = 5'd16;
   localparam logic [4:0] S_DONE  = 5'd17;

   logic [4:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 closed_ff, closed_in;
   logic [1:0]           tstat_ff, tstat_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [1:0]           pstat_ff, pstat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 accept;
   logic [CNT_W-1:0]     eff_count;
   logic                 room;
   logic [CNT_W-1:0]     last_cnt;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign eff_count = closed_ff ? '0 : count_ff;
   assign room      = (eff_count < CNT_W'(MAX_POINTS));
   assign last_cnt  = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      closed_in     = closed_ff;
      tstat_in      = tstat_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      dcnt_in       = dcnt_ff;
      pstat_in      = pstat_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      c_addr        = idx_ff;
      x_addr        = idx_ff;
      wr_addr       = i_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CMD_LOAD)) begin
               // Store the point or drop it when the table is full
               wr_addr       = eff_count[IDX_W-1:0];
               cmd.x_wr      = room;
               cmd.c_wr_load = room;
               count_in      = eff_count + CNT_W'(room);
               closed_in     = 1'b0;
               if (!room) begin
                  tstat_in = STATUS_TOO_MANY;
               end else if (closed_ff) begin
                  tstat_in = STATUS_OK;
               end
               if (req_last_point) begin
                  if (count_in >= CNT_W'(2)) begin
                     i_in     = IDX_W'(count_in - CNT_W'(1));
                     j_in     = IDX_W'(1);
                     state_in = S_B_RD1;
                  end else begin
                     closed_in = 1'b1;
                  end
               end
            end else if (accept) begin
               cmd.qx_load = 1'b1;
               if (!closed_ff || (count_ff == '0) || (tstat_ff == STATUS_EMPTY)) begin
                  cmd.pend_zero = 1'b1;
                  pstat_in      = STATUS_EMPTY;
                  state_in      = S_DONE;
               end else if (tstat_ff == STATUS_DUP_X) begin
                  cmd.pend_zero = 1'b1;
                  pstat_in      = STATUS_DUP_X;
                  state_in      = S_DONE;
               end else begin
                  pstat_in = tstat_ff;
                  idx_in   = last_cnt[IDX_W-1:0];
                  state_in = S_Q_RD0;
               end
            end
         end
         S_B_RD1: begin
            c_addr   = i_ff;
            x_addr   = i_ff;
            state_in = S_B_RD2;
         end
         S_B_RD2: begin
            c_addr    = i_ff - IDX_W'(1);
            x_addr    = i_ff - j_ff;
            cmd.cap_a = 1'b1;
            state_in  = S_B_CAP;
         end
         S_B_CAP: begin
            cmd.cap_b = 1'b1;
            state_in  = S_B_PRE;
         end
         S_B_PRE: begin
            cmd.prep = 1'b1;
            state_in = S_B_CHK;
         end
         S_B_CHK: begin
            // Stop the build on a repeated abscissa
            if (den_zero) begin
               tstat_in  = STATUS_DUP_X;
               closed_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               dcnt_in      = DIV_CNT_W'(DIV_STEPS - 1);
               state_in     = S_B_DIV;
            end
         end
         S_B_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff - DIV_CNT_W'(1);
            if (dcnt_ff == '0) begin
               state_in = S_B_WR;
            end
         end
         S_B_WR: begin
            cmd.c_wr_div = 1'b1;
            if (i_ff == j_ff) begin
               if ((CNT_W'(j_ff) + CNT_W'(1)) == count_ff) begin
                  closed_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  i_in     = last_cnt[IDX_W-1:0];
                  state_in = S_B_RD1;
               end
            end else begin
               i_in     = i_ff - IDX_W'(1);
               state_in = S_B_RD1;
            end
         end
         S_Q_RD0: begin
            state_in = S_Q_LD;
         end
         S_Q_LD: begin
            cmd.acc_load = 1'b1;
            if (idx_ff == '0) begin
               state_in = S_Q_FIN;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = S_Q_RD;
            end
         end
         S_Q_RD: begin
            state_in = S_Q_CAP;
         end
         S_Q_CAP: begin
            cmd.q_cap = 1'b1;
            state_in  = S_Q_ML;
         end
         S_Q_ML: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_Q_MH;
         end
         S_Q_MH: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_Q_SUM;
         end
         S_Q_SUM: begin
            cmd.q_sum = 1'b1;
            state_in  = S_Q_ADD;
         end
         S_Q_ADD: begin
            cmd.q_add = 1'b1;
            if (idx_ff == '0) begin
               state_in = S_Q_FIN;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = S_Q_RD;
            end
         end
         S_Q_FIN: begin
            cmd.q_fin = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pstat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b1;
         tstat_ff     <= STATUS_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         tstat_ff     <= tstat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      idx_ff        <= idx_in;
      dcnt_ff       <= dcnt_in;
      pstat_ff      <= pstat_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: design/newton_divided_difference_interp_unit.sv
// Load item: stored in the table when accepted. The last load builds the coefficients with
// n(n-1)/2 divisions in the bit-serial divider.
// Query item: Horner evaluation over the n stored points into the output register;
// each Horner step runs one 32x33 multiplier twice.
// Synchronous reset clears control state and empties the table; the point
// and coefficient memories are not cleared.
module newton_divided_difference_interp_unit import nddi_pkg::*; #(
   parameter int MAX_POINTS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status
);

   localparam int IDX_W = $clog2(MAX_POINTS);

   nddi_cmd_type     cmd;
   logic             den_zero;
   logic [IDX_W-1:0] c_addr;
   logic [IDX_W-1:0] x_addr;
   logic [IDX_W-1:0] wr_addr;

   nddi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .den_zero       (den_zero),
      .cmd            (cmd),
      .c_addr         (c_addr),
      .x_addr         (x_addr),
      .wr_addr        (wr_addr)
   );

   nddi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .c_addr           (c_addr),
      .x_addr           (x_addr),
      .wr_addr          (wr_addr),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .den_zero         (den_zero),
      .rsp_result_value (rsp_result_value)
   );

endmodule

FILE: bench/newton_divided_difference_interp_unit_test.sv
module newton_divided_difference_interp_unit_test;
   import nddi_pkg::*;

   localparam int NPTS = 7;
   localparam int STALL_LIMIT = 200000;
   localparam int TAIL_CYCLES = 200;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } interp_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_cmd;
   logic signed [31:0] req_x_value;
   logic signed [31:0] req_y_value;
   logic               req_last_point;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;

   // Predictor state
   logic [63:0] tbl_x [NPTS];
   logic [63:0] tbl_c [NPTS];
   int          tbl_count;
   bit          tbl_closed;
   logic [1:0]  tbl_status;

   interp_result_type expected_results[$];
   int  error_count;
   int  idle_cycles;
   int  sender_idle_pct;
   int  receiver_stall_pct;
   bit  hold_receiver;
   bit  start_hold;

   newton_divided_difference_interp_unit #(.MAX_POINTS(NPTS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_x_value      (req_x_value),
      .req_y_value      (req_y_value),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] signed_sat(input bit neg, input logic [63:0] m);
      if (neg) begin
         if (m > 64'h8000_0000_0000_0000) m = 64'h8000_0000_0000_0000;
         signed_sat = ~m + 64'd1;
      end else begin
         signed_sat = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
      end
   endfunction

   function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         add_clamped = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else
         add_clamped = s;
   endfunction

   // Exact a - b split into sign and magnitude
   function automatic logic [63:0] exact_diff(input logic [63:0] a, input logic [63:0] b,
                                              output bit neg);
      logic [63:0] s;
      if (a[63] != b[63]) begin
         neg = a[63];
         exact_diff = a[63] ? (mag64(a) + b) : (a + mag64(b));
      end else begin
         s = a - b;
         neg = s[63];
         exact_diff = mag64(s);
      end
   endfunction

   function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
      logic [79:0] q;
      q = {num, 16'd0} / {16'd0, den};
      scaled_quotient = (q[79:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
   endfunction

   function automatic logic [63:0] horner_product(input logic [63:0] c, input logic [63:0] d);
      logic [63:0]  a, b;
      logic [127:0] p;
      logic [111:0] m;
      a = mag64(c);
      b = mag64(d);
      p = a * b;
      m = p[127:16];
      horner_product = signed_sat(c[63] ^ d[63],
                                  (m[111:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : m[63:0]);
   endfunction

   task automatic build_coefficients();
      bit nn, nd;
      logic [63:0] num, den;
      for (int j = 1; j < tbl_count; j++) begin
         for (int i = tbl_count - 1; i >= j; i--) begin
            num = exact_diff(tbl_c[i], tbl_c[i-1], nn);
            den = exact_diff(tbl_x[i], tbl_x[i-j], nd);
            if (den == 0) begin
               tbl_status = STATUS_DUP_X;
               return;
            end
            tbl_c[i] = signed_sat(nn != nd, scaled_quotient(num, den));
         end
      end
   endtask

   // Advance the predictor by one accepted item
   task automatic predict_item(input logic cmd, input logic [31:0] xv, input logic [31:0] yv,
                               input logic lastp);
      logic [63:0] x, acc, m;
      interp_result_type r;
      x = {{32{xv[31]}}, xv};
      if (cmd == CMD_LOAD) begin
         if (tbl_closed) begin
            tbl_count = 0;
            tbl_status = STATUS_OK;
            tbl_closed = 0;
         end
         if (tbl_count < NPTS) begin
            tbl_x[tbl_count] = x;
            tbl_c[tbl_count] = {{16{yv[31]}}, yv, 16'd0};
            tbl_count++;
         end else begin
            tbl_status = STATUS_TOO_MANY;
         end
         if (lastp) begin
            build_coefficients();
            tbl_closed = 1;
         end
         return;
      end
      if (!tbl_closed || tbl_count == 0 || tbl_status == STATUS_EMPTY) begin
         r.value = 0;
         r.status = STATUS_EMPTY;
      end else if (tbl_status == STATUS_DUP_X) begin
         r.value = 0;
         r.status = STATUS_DUP_X;
      end else begin
         acc = tbl_c[tbl_count-1];
         for (int i = tbl_count - 2; i >= 0; i--)
            acc = add_clamped(horner_product(acc, x - tbl_x[i]), tbl_c[i]);
         m = mag64(acc) >> 16;
         if (acc[63]) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            m = ~m + 64'd1;
         end else if (m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
         end
         r.value = m[31:0];
         r.status = tbl_status;
      end
      expected_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // Send one item, idling first at the current rate
   task automatic send_item(input logic cmd, input logic [31:0] xv, input logic [31:0] yv,
                            input logic lastp);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_x_value    <= xv;
      req_y_value    <= yv;
      req_last_point <= lastp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cmd, xv, yv, lastp);
   endtask

   // Drain: drop valid, wait until all results are in, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_x_small();
      rand_x_small = $signed($urandom_range(0, 20 << 16)) - $signed(10 << 16);
   endfunction

   task automatic load_table(input int n, input bit wide);
      for (int i = 0; i < n; i++)
         send_item(CMD_LOAD, wide ? $urandom : rand_x_small(),
                   wide ? $urandom : rand_x_small(), i == n - 1);
   endtask

   task automatic test_directed();
      send_item(CMD_QUERY, 32'h0001_0000, 32'h0, 1'b0);
      send_item(CMD_LOAD, 32'h0, 32'h0001_0000, 1'b0);
      send_item(CMD_QUERY, 32'h0, 32'h0, 1'b0);
      send_item(CMD_LOAD, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0);
      send_item(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 1'b1);
      send_item(CMD_QUERY, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_item(CMD_QUERY, 32'h8000_0000, 32'h0, 1'b1);
      // Duplicate abscissa
      send_item(CMD_LOAD, 32'h0002_0000, 32'h5, 1'b0);
      send_item(CMD_LOAD, 32'h0002_0000, 32'h9, 1'b1);
      send_item(CMD_QUERY, 32'h1, 32'h0, 1'b0);
      // Overfull table
      for (int i = 0; i < NPTS + 2; i++)
         send_item(CMD_LOAD, i << 15, $urandom, i == NPTS + 1);
      send_item(CMD_QUERY, 32'h0000_8000, 32'h0, 1'b0);
      send_item(CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 1'b0);
      // Single point
      send_item(CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_item(CMD_QUERY, 32'h0, 32'h0, 1'b0);
      wait_idle();
   endtask

   task automatic test_random(input int items, input int sidle, input int rstall);
      int sent;
      int n;
      sender_idle_pct = sidle;
      receiver_stall_pct = rstall;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0: begin
               send_item(1'($urandom), $urandom, $urandom, 1'($urandom));
               sent++;
            end
            1, 2: begin
               n = $urandom_range(1, NPTS + 2);
               load_table(n, $urandom_range(3) == 0);
               sent += n;
            end
            default: begin
               send_item(CMD_QUERY, ($urandom_range(4) == 0) ? $urandom : rand_x_small(),
                         $urandom, 1'($urandom));
               sent++;
            end
         endcase
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      load_table(2, 1'b0);
      start_hold = 1;
      for (int i = 0; i < 10; i++) send_item(CMD_QUERY, rand_x_small(), 32'h0, 1'b0);
      wait_idle();
   endtask

   // Receiver side: drive ready and check each result
   always @(posedge clock) begin
      interp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_result_value, 32'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
            end
         end
         rsp_ready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Hold off the receiver for a long stretch while items keep arriving
   initial begin
      int held;
      hold_receiver = 0;
      wait (start_hold);
      hold_receiver = 1;
      held = 0;
      while (held < 400) begin
         @(posedge clock);
         held++;
      end
      hold_receiver = 0;
   end

   // Watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      start_hold = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      tbl_count = 0;
      tbl_closed = 1;
      tbl_status = STATUS_EMPTY;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD;
      req_x_value = '0;
      req_y_value = '0;
      req_last_point = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(140, 0, 0);
      test_random(140, 75, 0);
      test_random(140, 0, 75);
      test_random(140, 13, 13);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: newton_divided_difference_interp_unit.f
design/nddi_pkg.sv
design/nddi_ram.sv
design/nddi_dp.sv
design/nddi_ctrl.sv
design/newton_divided_difference_interp_unit.sv
bench/newton_divided_difference_interp_unit_test.sv
